@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Assertion on the standard clk_i / rst_ni pair.
`define ASSERT_STD(name, prop) `ASSERT_CLK(name, clk_i, rst_ni, prop)

`endif

@@ hw/rtl/rms_pkg.sv @@
// ---------------------------------------------------------------------------
// rms_pkg
// Widths and constants of the running median smoother.
// ---------------------------------------------------------------------------
`default_nettype none

package rms_pkg;

  // Sample and result width.
  localparam int unsigned SampleW = 32;

  // Default window length (samples).
  localparam int unsigned WindowDef = 9;

  // x / 5 == (x * DivFiveMul) >> DivFiveShift for every 32-bit x.
  localparam logic [SampleW-1:0] DivFiveMul   = 32'hCCCC_CCCD;
  localparam int unsigned        DivFiveShift = 34;

endpackage

`default_nettype wire

@@ hw/rtl/rms_stream_if.sv @@
// ---------------------------------------------------------------------------
// rms_sample_if / rms_filtered_if
// Valid/ready channels for samples in and filtered results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface rms_sample_if;
  import rms_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rms_filtered_if;
  import rms_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/running_median_smoother.sv @@
// ---------------------------------------------------------------------------
// running_median_smoother
// Running median over a window of samples, followed by 4/5 smoothing.
// ---------------------------------------------------------------------------
// Takes one item per clock and gives one result per item, in order. Each
// sample replaces the oldest of Window stored samples (all zero after reset,
// so the first results are pulled toward zero). The median (rank Window/2,
// ascending) is smoothed as filtered = floor((4*prev + median) / 5), where
// prev is the previous result (zero after reset). An accepted item passes
// the window, median and result registers in turn; throughput is one item
// per cycle, set by the result stage, whose feedback of the previous result
// through the divide-by-five reciprocal multiply closes each item before
// the next. A full pipeline stalls only when the result is not taken.
`default_nettype none

`include "assert_macros.svh"

module running_median_smoother #(
  parameter int unsigned Window = rms_pkg::WindowDef
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  rms_sample_if.sink     in_i,
  rms_filtered_if.source out_o
);
  import rms_pkg::*;

  localparam int unsigned    SlotW   = $clog2(Window);
  localparam int unsigned    RankW   = $clog2(Window);
  localparam logic [SlotW-1:0] SlotLast = SlotW'(Window - 1);
  localparam logic [RankW-1:0] MidRank  = RankW'(Window / 2);

  // ---- stage 1: sample window -------------------------------------------
  logic [SampleW-1:0] window_q [Window];
  logic [SampleW-1:0] window_d [Window];
  logic [SlotW-1:0]   slot_q, slot_d;
  logic               win_vld_q;     // window holds an item not yet ranked

  // ---- stage 2: median ----------------------------------------------------
  logic [SampleW-1:0] median_q, median_d;
  logic               med_vld_q;

  // ---- stage 3: result register (also the previous result) ---------------
  logic [SampleW-1:0] filt_q, filt_d;
  logic               out_vld_q;

  logic in_fire;
  logic med_adv;   // stage 2 may load
  logic out_adv;   // result register may load

  assign out_adv   = ~out_vld_q | out_o.ready;
  assign med_adv   = ~med_vld_q | out_adv;
  assign in_i.ready = ~win_vld_q | med_adv;
  assign in_fire   = in_i.valid & in_i.ready;

  // New sample overwrites the oldest slot; slot pointer wraps.
  always_comb begin
    for (int i = 0; i < Window; i++) begin
      window_d[i] = window_q[i];
      if (in_fire && slot_q == SlotW'(i)) begin
        window_d[i] = in_i.sample;
      end
    end
    slot_d = slot_q;
    if (in_fire) begin
      slot_d = (slot_q >= SlotLast) ? '0 : slot_q + 1'b1;
    end
  end

  // Median by rank counting: rank of entry i counts smaller entries plus
  // equal entries at lower index, so every entry gets a distinct rank and
  // exactly one entry carries the middle rank.
  logic [RankW-1:0] rank [Window];

  always_comb begin
    for (int i = 0; i < Window; i++) begin
      rank[i] = '0;
      for (int j = 0; j < Window; j++) begin
        if (window_q[j] < window_q[i] || (j < i && window_q[j] == window_q[i])) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end
    median_d = '0;
    for (int i = 0; i < Window; i++) begin
      if (rank[i] == MidRank) begin
        median_d = median_d | window_q[i];
      end
    end
  end

  // Smoothing: (4y + m)/5 = y + floor((m - y)/5). For negative d = m - y,
  // floor(d/5) = ~(~d / 5) with ~d the non-negative one's complement, so a
  // single unsigned 32-bit divide-by-five serves both signs.
  logic [SampleW:0]     diff;
  logic                 diff_neg;
  logic [SampleW-1:0]   div_in;
  logic [2*SampleW-1:0] div_prod;
  logic [SampleW-1:0]   div_quo;
  logic [SampleW-1:0]   step;

  always_comb begin
    diff     = {1'b0, median_q} - {1'b0, filt_q};
    diff_neg = diff[SampleW];
    div_in   = diff_neg ? ~diff[SampleW-1:0] : diff[SampleW-1:0];
    div_prod = (2*SampleW)'(div_in) * (2*SampleW)'(DivFiveMul);
    div_quo  = SampleW'(div_prod >> DivFiveShift);
    step     = diff_neg ? ~div_quo : div_quo;
    filt_d   = filt_q + step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Window; i++) begin
        window_q[i] <= '0;
      end
      slot_q    <= '0;
      win_vld_q <= 1'b0;
      med_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      filt_q    <= '0;
    end else begin
      window_q <= window_d;
      slot_q   <= slot_d;
      if (in_i.ready) begin
        win_vld_q <= in_fire;
      end
      if (med_adv) begin
        med_vld_q <= win_vld_q;
      end
      if (out_adv) begin
        out_vld_q <= med_vld_q;
      end
      if (out_adv && med_vld_q) begin
        filt_q <= filt_d;
      end
    end
  end

  // Median register is payload only.
  always_ff @(posedge clk_i) begin
    if (med_adv && win_vld_q) begin
      median_q <= median_d;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.filtered = filt_q;

  // ---- assertions ---------------------------------------------------------
  `ASSERT_STD(a_accept_fills_window, (in_fire |=> win_vld_q))
  `ASSERT_STD(a_empty_is_ready, ((!win_vld_q && !med_vld_q && !out_vld_q) |-> in_i.ready))
  `ASSERT_STD(a_median_reaches_out, ((med_vld_q && out_adv) |=> out_vld_q))
  `ASSERT_STD(a_slot_wraps, ((in_fire && slot_q == SlotLast) |=> (slot_q == '0)))

endmodule

`default_nettype wire
